// File: design/eipf_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser and filter.
// No dependencies; imported by every design module.
`default_nettype none

package eipf_pkg;

   // Verdict codes
   localparam logic [3:0] VERDICT_ACCEPT    = 4'd0;
   localparam logic [3:0] VERDICT_SHORT_ETH = 4'd1;
   localparam logic [3:0] VERDICT_NOT_IPV4  = 4'd2;
   localparam logic [3:0] VERDICT_SHORT_IP  = 4'd3;
   localparam logic [3:0] VERDICT_BAD_VER   = 4'd4;
   localparam logic [3:0] VERDICT_SHORT_TCP = 4'd5;
   localparam logic [3:0] VERDICT_SHORT_UDP = 4'd6;
   localparam logic [3:0] VERDICT_OTHER     = 4'd7;
   localparam logic [3:0] VERDICT_FILTERED  = 4'd8;

   // Transport kind codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TCP  = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;

   // CSR register indexes
   localparam logic [1:0] CSR_TARGET    = 2'd0;
   localparam logic [1:0] CSR_GATEWAY   = 2'd1;
   localparam logic [1:0] CSR_INTERCEPT = 2'd2;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [15:0] eth_type;
      logic [7:0]  ver_ihl;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [31:0] port_pair;
      logic [3:0]  tcp_words;
   } hdr_type;

   typedef struct packed {
      logic [31:0] target_address;
      logic [31:0] gateway_address;
      logic        intercept_enable;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic [47:0] source_mac;
      logic [47:0] dest_mac;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [1:0]  transport_kind;
      logic [7:0]  payload_offset;
      logic [11:0] payload_length;
      logic [11:0] frame_length;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/eipf_if.sv
// Handshake channel interfaces: frame bytes in, verdicts out, CSR writes.
// Depends on eipf_pkg for nothing but field widths that are fixed here.
`default_nettype none

interface eipf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;
   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface eipf_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [47:0] source_mac;
   logic [47:0] dest_mac;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [1:0]  transport_kind;
   logic [7:0]  payload_offset;
   logic [11:0] payload_length;
   logic [11:0] frame_length;
   modport source (output valid, verdict, source_mac, dest_mac, source_address,
                   dest_address, source_port, dest_port, transport_kind,
                   payload_offset, payload_length, frame_length, input ready);
   modport sink   (input valid, verdict, source_mac, dest_mac, source_address,
                   dest_address, source_port, dest_port, transport_kind,
                   payload_offset, payload_length, frame_length, output ready);
endinterface

interface eipf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [31:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// File: design/eipf_capture.sv
// Per-frame header capture: byte counter and field shift registers.
// Depends on eipf_pkg (hdr_type).
`default_nettype none

module eipf_capture
   import eipf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 2048,
   parameter int POS_W = $clog2(MAX_FRAME_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       frame_byte,
   input  wire logic             frame_last,
   output hdr_type              hdr_nx,
   output logic     [POS_W-1:0] len_nx
);

   hdr_type          hdr_ff;
   logic [POS_W-1:0] pos_ff;
   logic [6:0]       l4;

   // next view of the header, including the byte now being stepped
   always_comb begin
      hdr_nx = hdr_ff;
      len_nx = pos_ff;
      l4     = 7'(7'd14 + {1'b0, hdr_ff.ver_ihl[3:0], 2'b00});
      if (pos_ff < POS_W'(MAX_FRAME_BYTES)) begin
         if (pos_ff < POS_W'(6)) begin
            hdr_nx.dest_mac = {hdr_ff.dest_mac[39:0], frame_byte};
         end else if (pos_ff < POS_W'(12)) begin
            hdr_nx.source_mac = {hdr_ff.source_mac[39:0], frame_byte};
         end else if (pos_ff < POS_W'(14)) begin
            hdr_nx.eth_type = {hdr_ff.eth_type[7:0], frame_byte};
         end
         if (pos_ff == POS_W'(14)) begin
            hdr_nx.ver_ihl = frame_byte;
         end
         if (pos_ff == POS_W'(23)) begin
            hdr_nx.protocol = frame_byte;
         end
         if (pos_ff >= POS_W'(26) && pos_ff < POS_W'(30)) begin
            hdr_nx.source_address = {hdr_ff.source_address[23:0], frame_byte};
         end
         if (pos_ff >= POS_W'(30) && pos_ff < POS_W'(34)) begin
            hdr_nx.dest_address = {hdr_ff.dest_address[23:0], frame_byte};
         end
         // transport offset follows the IHL as just updated
         l4 = 7'(7'd14 + {1'b0, hdr_nx.ver_ihl[3:0], 2'b00});
         if (pos_ff >= POS_W'(l4) && pos_ff < POS_W'(l4) + POS_W'(4)) begin
            hdr_nx.port_pair = {hdr_ff.port_pair[23:0], frame_byte};
         end
         if (pos_ff == POS_W'(l4) + POS_W'(12)) begin
            hdr_nx.tcp_words = frame_byte[7:4];
         end
         len_nx = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
         pos_ff <= '0;
      end else if (step) begin
         if (frame_last) begin
            hdr_ff <= '0;
            pos_ff <= '0;
         end else begin
            hdr_ff <= hdr_nx;
            pos_ff <= len_nx;
         end
      end
   end

endmodule

`default_nettype wire

// File: design/eipf_classify.sv
// End-of-frame classification, address filter and payload offset math.
// Depends on eipf_pkg (hdr_type, cfg_type, rsp_type, codes).
`default_nettype none

module eipf_classify
   import eipf_pkg::*;
#(
   parameter int POS_W = 12
) (
   input  wire hdr_type          hdr,
   input  wire logic [POS_W-1:0] len,
   input  wire cfg_type          cfg,
   output rsp_type              rsp
);

   localparam int CW = ((POS_W > 9) ? POS_W : 9) + 1;

   logic [CW-1:0] len_w;
   logic [CW-1:0] off_w;
   logic [CW-1:0] plen_w;
   logic [7:0]    off0;
   logic [7:0]    off;
   logic [3:0]    verdict;
   logic [1:0]    kind;
   logic          hit;

   always_comb begin
      len_w   = CW'(len);
      off0    = 8'(8'd14 + {2'b00, hdr.ver_ihl[3:0], 2'b00});
      off     = off0;
      kind    = KIND_NONE;
      verdict = VERDICT_ACCEPT;
      if (len_w < CW'(14)) begin
         verdict = VERDICT_SHORT_ETH;
      end else if (hdr.eth_type != ETHERTYPE_IPV4) begin
         verdict = VERDICT_NOT_IPV4;
      end else if (len_w < CW'(34)) begin
         verdict = VERDICT_SHORT_IP;
      end else if (hdr.ver_ihl[7:4] != IP_VERSION_4) begin
         verdict = VERDICT_BAD_VER;
      end else if (hdr.protocol == PROTO_TCP) begin
         if (len_w < CW'(off0) + CW'(20)) begin
            verdict = VERDICT_SHORT_TCP;
         end else begin
            kind = KIND_TCP;
            off  = 8'(off0 + {2'b00, hdr.tcp_words, 2'b00});
         end
      end else if (hdr.protocol == PROTO_UDP) begin
         if (len_w < CW'(off0) + CW'(8)) begin
            verdict = VERDICT_SHORT_UDP;
         end else begin
            kind = KIND_UDP;
            off  = 8'(off0 + 8'd8);
         end
      end else begin
         verdict = VERDICT_OTHER;
      end

      hit = (hdr.source_address == cfg.target_address) ||
            (hdr.dest_address == cfg.target_address) ||
            (cfg.intercept_enable &&
             ((hdr.source_address == cfg.gateway_address) ||
              (hdr.dest_address == cfg.gateway_address)));
      if (verdict == VERDICT_ACCEPT && !hit) begin
         verdict = VERDICT_FILTERED;
      end

      off_w  = CW'(off);
      plen_w = (off_w < len_w) ? len_w - off_w : '0;

      rsp              = '0;
      rsp.verdict      = verdict;
      rsp.frame_length = 12'(len);
      if (verdict == VERDICT_ACCEPT || verdict == VERDICT_FILTERED) begin
         rsp.source_mac     = hdr.source_mac;
         rsp.dest_mac       = hdr.dest_mac;
         rsp.source_address = hdr.source_address;
         rsp.dest_address   = hdr.dest_address;
         rsp.source_port    = hdr.port_pair[31:16];
         rsp.dest_port      = hdr.port_pair[15:0];
         rsp.transport_kind = kind;
         rsp.payload_offset = off;
         rsp.payload_length = 12'(plen_w);
      end
   end

endmodule

`default_nettype wire

// File: design/eth_ipv4_l4_header_parse_filter.sv
// Top level of the Ethernet/IPv4/TCP-UDP header parser and address filter.
// Depends on eipf_pkg, eipf_if, eipf_capture and eipf_classify.
//
// Usage:
//  - req_chan carries one frame byte per word, frame_last on the final byte;
//    bytes may come every cycle; the block takes one per cycle unless stalled.
//  - rsp_chan gives exactly one verdict word per frame, after the last byte
//    has passed through the byte input register and the result register.
//  - csr_chan writes target address (index 0), gateway address (1) and
//    intercept enable (2); always ready, write only while idle.
//  - Throughput: one byte per cycle unless stalled, set by the byte input
//    register feeding the capture logic; the verdict is formed in the same
//    cycle that the last byte is captured and held in the result register.
//  - Receiver stall: a verdict waiting in the result register holds the next
//    last byte and all bytes behind it; earlier bytes keep flowing into capture.
//  - Reset (synchronous, active high) clears the frame state, both channel
//    registers and the CSRs (addresses zero, intercept off).
//  - Bytes past MAX_FRAME_BYTES are neither counted nor captured.
`default_nettype none

module eth_ipv4_l4_header_parse_filter
   import eipf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire logic       clock,
   input  wire logic       reset,
   eipf_req_if.sink        req_chan,
   eipf_rsp_if.source      rsp_chan,
   eipf_csr_if.sink        csr_chan
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   // byte input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic       out_valid_ff;
   rsp_type    out_ff;

   cfg_type    cfg_ff;

   hdr_type          hdr_nx;
   logic [POS_W-1:0] len_nx;
   rsp_type          rsp_in;
   logic             advance;
   logic             req_take;

   // a byte moves on unless it ends a frame and the result slot is still full
   assign advance  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.frame_byte;
         in_last_ff <= req_chan.frame_last;
      end
   end

   eipf_capture #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .POS_W           (POS_W)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .frame_byte (in_byte_ff),
      .frame_last (in_last_ff),
      .hdr_nx     (hdr_nx),
      .len_nx     (len_nx)
   );

   eipf_classify #(
      .POS_W (POS_W)
   ) u_classify (
      .hdr (hdr_nx),
      .len (len_nx),
      .cfg (cfg_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.verdict        = out_ff.verdict;
   assign rsp_chan.source_mac     = out_ff.source_mac;
   assign rsp_chan.dest_mac       = out_ff.dest_mac;
   assign rsp_chan.source_address = out_ff.source_address;
   assign rsp_chan.dest_address   = out_ff.dest_address;
   assign rsp_chan.source_port    = out_ff.source_port;
   assign rsp_chan.dest_port      = out_ff.dest_port;
   assign rsp_chan.transport_kind = out_ff.transport_kind;
   assign rsp_chan.payload_offset = out_ff.payload_offset;
   assign rsp_chan.payload_length = out_ff.payload_length;
   assign rsp_chan.frame_length   = out_ff.frame_length;

   // CSR writes; index 3 is ignored
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_TARGET:    cfg_ff.target_address   <= csr_chan.wr_data;
            CSR_GATEWAY:   cfg_ff.gateway_address  <= csr_chan.wr_data;
            CSR_INTERCEPT: cfg_ff.intercept_enable <= csr_chan.wr_data[0];
            default:       ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: design/eipf_checker.sv
// Port-level checks for the header parser and filter, bound to the top level.
// Depends on eipf_pkg (verdict and kind codes).
`default_nettype none

module eipf_checker
   import eipf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  verdict,
   input wire logic [1:0]  transport_kind,
   input wire logic [7:0]  payload_offset,
   input wire logic [15:0] source_port
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("verdict valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict dropped while stalled");

   // error verdicts carry no transport information
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && verdict != VERDICT_ACCEPT && verdict != VERDICT_FILTERED
      |-> transport_kind == KIND_NONE && payload_offset == 8'd0 && source_port == 16'd0)
      else $error("error verdict with transport fields");

   // a parsed frame is always TCP or UDP with a payload offset past the Ethernet header
   a_parsed_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (verdict == VERDICT_ACCEPT || verdict == VERDICT_FILTERED)
      |-> (transport_kind == KIND_TCP || transport_kind == KIND_UDP) &&
          payload_offset >= 8'd14)
      else $error("parsed verdict without valid transport");

endmodule

bind eth_ipv4_l4_header_parse_filter eipf_checker u_eipf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .verdict        (rsp_chan.verdict),
   .transport_kind (rsp_chan.transport_kind),
   .payload_offset (rsp_chan.payload_offset),
   .source_port    (rsp_chan.source_port)
);

`default_nettype wire
